// ===== rtl/sss_pkg.sv =====
package sss_pkg;

	// Default sizing of the element stores.
	localparam int MAX_ELEMS_DEF  = 64;
	localparam int ELEM_WIDTH_DEF = 32;

	// Fixed widths of the channel fields.
	localparam int VALUE_W = 32;
	localparam int COUNT_W = 7;
	// Width used for sign extension between element and field widths.
	localparam int EXT_W   = 64;

	// Operation codes of an input beat. Code 3 is unused and ignored.
	typedef enum logic [1:0] {
		FUNC_LOAD_TGT = 2'd0,
		FUNC_LOAD_REM = 2'd1,
		FUNC_RUN      = 2'd2
	} func_t;

	typedef struct packed {
		logic [1:0]                 func;
		logic signed [VALUE_W-1:0]  value;
	} in_item_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0]  elem_out;
		logic                       last;
		logic                       empty_res;
		logic [COUNT_W-1:0]         remaining_count;
		logic                       overflow;
	} out_item_t;

endpackage

// ===== rtl/sss_in_if.sv =====
interface sss_in_if;
	logic              valid;
	logic              ready;
	sss_pkg::in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/sss_out_if.sv =====
interface sss_out_if;
	logic               valid;
	logic               ready;
	sss_pkg::out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/sorted_set_subtract.sv =====
// Channel   Role    Payload                                            Beat taken when
// items     sink    func, value                                        valid && ready
// results   source  elem_out, last, empty_res, remaining_count,        valid && ready
//                   overflow
//
// A load beat is written straight into its store; a beat for a full store is dropped
// and sets the overflow flag. A run walks the intersection, then the difference, then
// emits the kept elements, or a single empty result; each step is one registered
// read of the stores, and an emission step waits while the output register is busy.
// Reset clears the counts, the overflow flag and the control state; store contents
// are left undefined, as only entries below the counts are ever read.
// The items channel is ready only between runs; a stalled results channel holds the
// emission walk, while a final result waiting in the output register does not block
// new load beats.
module sorted_set_subtract #(
	parameter int MAX_ELEMS  = sss_pkg::MAX_ELEMS_DEF,
	parameter int ELEM_WIDTH = sss_pkg::ELEM_WIDTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	sss_in_if.sink     items,
	sss_out_if.source  results
);

	localparam int AW = $clog2(MAX_ELEMS);
	localparam int CW = $clog2(MAX_ELEMS + 1);

	typedef logic [ELEM_WIDTH-1:0] elem_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ISECT_RD,
		ST_ISECT_CMP,
		ST_DIFF_RD,
		ST_DIFF_CMP,
		ST_EMIT_RD,
		ST_EMIT_WAIT,
		ST_EMIT_EMPTY
	} state_t;

	state_t             state_q;
	logic [CW-1:0]      tgt_cnt_q;
	logic [CW-1:0]      rem_cnt_q;
	logic               ovf_q;
	logic [CW-1:0]      i_q;
	logic [CW-1:0]      j_q;
	logic [CW-1:0]      nc_q;
	logic [CW-1:0]      nk_q;
	logic               out_valid_q;
	sss_pkg::out_item_t out_data_q;

	// The two element stores. Each has one write port and one registered read port.
	elem_t   tgt_mem [MAX_ELEMS];
	elem_t   rem_mem [MAX_ELEMS];
	elem_t   tgt_rd_q;
	elem_t   rem_rd_q;

	logic          tgt_we, rem_we, tgt_re, rem_re;
	logic [AW-1:0] tgt_waddr, rem_waddr, tgt_raddr, rem_raddr;
	elem_t         tgt_wdata, rem_wdata;

	logic                   in_acc;
	logic                   out_free;
	logic                   out_load;
	logic [sss_pkg::EXT_W-1:0] value_ext;
	logic [sss_pkg::EXT_W-1:0] elem_ext;
	elem_t                  load_elem;
	logic                   tgt_room, rem_room;
	logic                   isect_go, diff_more, diff_pair, diff_tail;
	logic                   cmp_eq, cmp_lt, emit_last;

	assign items.ready   = (state_q == ST_IDLE);
	assign in_acc        = items.valid && items.ready;
	assign results.valid = out_valid_q;
	assign results.data  = out_data_q;

	// The output register is free when it is empty or its beat is being taken now.
	assign out_free = !out_valid_q || results.ready;
	// A new result beat enters the output register in this cycle.
	assign out_load = out_free && ((state_q == ST_EMIT_WAIT) || (state_q == ST_EMIT_EMPTY));

	// The value field is sign-extended, then kept in the element width.
	assign value_ext = sss_pkg::EXT_W'($signed(items.data.value));
	assign load_elem = value_ext[ELEM_WIDTH-1:0];
	// A stored element is sign-extended back and cut to the field width.
	assign elem_ext  = sss_pkg::EXT_W'($signed(tgt_rd_q));

	assign tgt_room  = (tgt_cnt_q < CW'(MAX_ELEMS));
	assign rem_room  = (rem_cnt_q < CW'(MAX_ELEMS));

	assign isect_go  = (i_q < tgt_cnt_q) && (j_q < rem_cnt_q);
	assign diff_more = (i_q < tgt_cnt_q);
	assign diff_pair = (j_q < nc_q);
	// Past the last matched element every remaining target element is kept.
	assign diff_tail = !(j_q < nc_q);

	assign cmp_eq    = (tgt_rd_q == rem_rd_q);
	assign cmp_lt    = ($signed(tgt_rd_q) < $signed(rem_rd_q));
	assign emit_last = (CW'(i_q + CW'(1)) == nk_q);

	// Store port control. The intersection is written back over the removal store and
	// the kept elements over the target store: the write index never passes the read
	// index of the same store, so nothing still to be read is overwritten.
	always_comb begin
		tgt_we    = 1'b0;
		rem_we    = 1'b0;
		tgt_re    = 1'b0;
		rem_re    = 1'b0;
		tgt_waddr = tgt_cnt_q[AW-1:0];
		rem_waddr = rem_cnt_q[AW-1:0];
		tgt_wdata = load_elem;
		rem_wdata = load_elem;
		tgt_raddr = i_q[AW-1:0];
		rem_raddr = j_q[AW-1:0];
		case (state_q)
			ST_IDLE: begin
				if (in_acc && items.data.func == sss_pkg::FUNC_LOAD_TGT) begin
					tgt_we = tgt_room;
				end
				if (in_acc && items.data.func == sss_pkg::FUNC_LOAD_REM) begin
					rem_we = rem_room;
				end
			end
			ST_ISECT_RD: begin
				tgt_re = isect_go;
				rem_re = isect_go;
			end
			ST_ISECT_CMP: begin
				rem_we    = cmp_eq;
				rem_waddr = nc_q[AW-1:0];
				rem_wdata = tgt_rd_q;
			end
			ST_DIFF_RD: begin
				tgt_re = diff_more;
				rem_re = diff_more && diff_pair;
			end
			ST_DIFF_CMP: begin
				tgt_we    = diff_tail || !cmp_eq;
				tgt_waddr = nk_q[AW-1:0];
				tgt_wdata = tgt_rd_q;
			end
			ST_EMIT_RD: begin
				tgt_re = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (tgt_we) begin
			tgt_mem[tgt_waddr] <= tgt_wdata;
		end
		if (tgt_re) begin
			tgt_rd_q <= tgt_mem[tgt_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (rem_we) begin
			rem_mem[rem_waddr] <= rem_wdata;
		end
		if (rem_re) begin
			rem_rd_q <= rem_mem[rem_raddr];
		end
	end

	// Sequencer: loads while idle, then intersection, difference and emission walks.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			tgt_cnt_q   <= '0;
			rem_cnt_q   <= '0;
			ovf_q       <= 1'b0;
			i_q         <= '0;
			j_q         <= '0;
			nc_q        <= '0;
			nk_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						case (items.data.func)
							sss_pkg::FUNC_LOAD_TGT: begin
								if (tgt_room) begin
									tgt_cnt_q <= CW'(tgt_cnt_q + CW'(1));
								end else begin
									ovf_q <= 1'b1;
								end
							end
							sss_pkg::FUNC_LOAD_REM: begin
								if (rem_room) begin
									rem_cnt_q <= CW'(rem_cnt_q + CW'(1));
								end else begin
									ovf_q <= 1'b1;
								end
							end
							sss_pkg::FUNC_RUN: begin
								i_q     <= '0;
								j_q     <= '0;
								nc_q    <= '0;
								state_q <= ST_ISECT_RD;
							end
							default: begin
							end
						endcase
					end
				end
				ST_ISECT_RD: begin
					if (isect_go) begin
						state_q <= ST_ISECT_CMP;
					end else begin
						i_q     <= '0;
						j_q     <= '0;
						nk_q    <= '0;
						state_q <= ST_DIFF_RD;
					end
				end
				ST_ISECT_CMP: begin
					if (cmp_eq) begin
						nc_q <= CW'(nc_q + CW'(1));
						i_q  <= CW'(i_q + CW'(1));
						j_q  <= CW'(j_q + CW'(1));
					end else if (cmp_lt) begin
						j_q <= CW'(j_q + CW'(1));
					end else begin
						i_q <= CW'(i_q + CW'(1));
					end
					state_q <= ST_ISECT_RD;
				end
				ST_DIFF_RD: begin
					if (diff_more) begin
						state_q <= ST_DIFF_CMP;
					end else begin
						i_q <= '0;
						if (nk_q == '0) begin
							state_q <= ST_EMIT_EMPTY;
						end else begin
							state_q <= ST_EMIT_RD;
						end
					end
				end
				ST_DIFF_CMP: begin
					if (!diff_tail && cmp_eq) begin
						j_q <= CW'(j_q + CW'(1));
					end else begin
						nk_q <= CW'(nk_q + CW'(1));
					end
					i_q     <= CW'(i_q + CW'(1));
					state_q <= ST_DIFF_RD;
				end
				ST_EMIT_RD: begin
					state_q <= ST_EMIT_WAIT;
				end
				ST_EMIT_WAIT: begin
					if (out_free) begin
						out_data_q.elem_out        <= elem_ext[sss_pkg::VALUE_W-1:0];
						out_data_q.last            <= emit_last;
						out_data_q.empty_res       <= 1'b0;
						out_data_q.remaining_count <= emit_last ?
							sss_pkg::COUNT_W'(nk_q) : '0;
						out_data_q.overflow        <= ovf_q;
						i_q                        <= CW'(i_q + CW'(1));
						if (emit_last) begin
							tgt_cnt_q <= '0;
							rem_cnt_q <= '0;
							ovf_q     <= 1'b0;
							state_q   <= ST_IDLE;
						end else begin
							state_q <= ST_EMIT_RD;
						end
					end
				end
				ST_EMIT_EMPTY: begin
					if (out_free) begin
						out_data_q.elem_out        <= '0;
						out_data_q.last            <= 1'b1;
						out_data_q.empty_res       <= 1'b1;
						out_data_q.remaining_count <= '0;
						out_data_q.overflow        <= ovf_q;
						tgt_cnt_q                  <= '0;
						rem_cnt_q                  <= '0;
						ovf_q                      <= 1'b0;
						state_q                    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	// The intersection written back must never overtake the removal read pointer.
	a_isect_inplace: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ISECT_CMP) |-> (nc_q <= j_q))
		else $error("intersection write index passed removal read index");

	// The kept list written back must never overtake the target read pointer.
	a_diff_inplace: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIFF_CMP) |-> (nk_q <= i_q))
		else $error("kept write index passed target read index");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(tgt_cnt_q <= CW'(MAX_ELEMS)) && (rem_cnt_q <= CW'(MAX_ELEMS)))
		else $error("store count beyond capacity");

	// A final result that carries an element also carries a nonzero count.
	a_last_count: assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && results.data.last && !results.data.empty_res)
		|-> (results.data.remaining_count != '0))
		else $error("final result without remaining count");

	a_run_start: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && items.data.func == sss_pkg::FUNC_RUN) |=> (state_q == ST_ISECT_RD))
		else $error("run beat did not start the intersection walk");
`endif

endmodule
